@@ rtl/core/sll_pkg.sv @@
// Shared types and codes of the static linked list engine.
package sll_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [9:0]  position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] result_value;
    logic        [9:0]  list_length;
  } out_item_t;

endpackage

@@ rtl/core/sll_store.sv @@
// Node store of the linked list: link and value memories with the pass that builds the free chain.
module sll_store #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_BITS   = 32,
  parameter int IW          = $clog2(STORE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 ready,
  input  logic                 link_we,
  input  logic [IW-1:0]        link_waddr,
  input  logic [IW-1:0]        link_wdata,
  input  logic [IW-1:0]        link_raddr,
  output logic [IW-1:0]        link_rdata,
  input  logic                 val_we,
  input  logic [IW-1:0]        val_waddr,
  input  logic [DATA_BITS-1:0] val_wdata,
  input  logic [IW-1:0]        val_raddr,
  output logic [DATA_BITS-1:0] val_rdata
);

  localparam logic [IW-1:0] LAST_NODE = IW'(STORE_DEPTH - 2);
  localparam logic [IW-1:0] TOP_NODE  = IW'(STORE_DEPTH - 1);

  logic [IW-1:0]        link_mem [STORE_DEPTH];
  logic [DATA_BITS-1:0] val_mem  [STORE_DEPTH];

  logic [IW-1:0] init_r, init_nxt;
  logic          init_busy_r, init_busy_nxt;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] wr_data;

  always_comb begin
    init_nxt      = init_r;
    init_busy_nxt = init_busy_r;
    if (init_busy_r) begin
      init_nxt = init_r + IW'(1);
      if (init_r == TOP_NODE) begin
        init_busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (init_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = init_r;
      if (init_r != '0 && init_r < LAST_NODE) begin
        wr_data = init_r + IW'(1);
      end else begin
        wr_data = '0;
      end
    end else begin
      wr_en   = link_we;
      wr_addr = link_waddr;
      wr_data = link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= '0;
      init_busy_r <= 1'b1;
    end else begin
      init_r      <= init_nxt;
      init_busy_r <= init_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rdata <= val_mem[val_raddr];
  end

  assign ready = !init_busy_r;

endmodule

@@ rtl/core/static_linked_list_engine.sv @@
// Top level of the static linked list engine: command sequencer around the node store.
//
// Commands arrive on the in_ channel (valid and stall); each transaction carries a
// command, a one-based position and a value. Every command gives exactly one result
// transaction on the out_ channel with a status, the value read or removed and the
// list length after the command.
// Insert, delete and read at position p walk the link chain one node per cycle, paced
// by the registered read of the link memory, so the position sets how long a command
// takes; an insert at the front is linked in S_POP without a walk. The result is loaded
// into the output register from S_DONE, and the next command can be accepted once the
// sequencer is back in S_IDLE. Clear walks the whole list and returns each node to the
// free chain. A rejected command goes straight to S_DONE. One command is worked on at a
// time; in_stall is low only while the sequencer is idle.
// A finished result waits in an output register; the next command is accepted and
// worked on while it waits, and only its own result waits for the register to drain.
// While out_stall is high the pending result holds still.
// After reset the link memory is rebuilt, one entry per cycle, as one free chain through
// nodes 1 to STORE_DEPTH - 2; in_stall stays high during that pass.
module static_linked_list_engine #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sll_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sll_pkg::out_item_t out_data
);

  import sll_pkg::*;

  localparam int IW   = $clog2(STORE_DEPTH);
  localparam int CMPW = ((IW > 10) ? IW : 10) + 1;
  localparam logic [IW-1:0] LAST_NODE = IW'(STORE_DEPTH - 2);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_WALK = 7'b0000100,
    S_LINK = 7'b0001000,
    S_TAIL = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic [9:0]           pos_r, pos_nxt;
  logic [DATA_BITS-1:0] val_r, val_nxt;
  logic [IW-1:0]        head_r, head_nxt;
  logic [IW-1:0]        free_r, free_nxt;
  logic [IW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        cur_r, cur_nxt;
  logic [IW-1:0]        prev_r, prev_nxt;
  logic [IW-1:0]        node_r, node_nxt;
  logic [9:0]           rem_r, rem_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [31:0]          result_r, result_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 store_ready;
  logic                 link_we;
  logic [IW-1:0]        link_waddr;
  logic [IW-1:0]        link_wdata;
  logic [IW-1:0]        link_raddr;
  logic [IW-1:0]        link_rdata;
  logic                 val_we;
  logic [DATA_BITS-1:0] val_rdata;

  logic                 accept;
  logic [CMPW-1:0]      pos_w;
  logic [CMPW-1:0]      cnt_w;
  logic signed [63:0]   val64;
  logic signed [DATA_BITS-1:0] rd_s;
  logic signed [63:0]   rd64;
  logic                 out_free;

  sll_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .DATA_BITS  (DATA_BITS),
    .IW         (IW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ready     (store_ready),
    .link_we   (link_we),
    .link_waddr(link_waddr),
    .link_wdata(link_wdata),
    .link_raddr(link_raddr),
    .link_rdata(link_rdata),
    .val_we    (val_we),
    .val_waddr (free_r),
    .val_wdata (val_r),
    .val_raddr (cur_r),
    .val_rdata (val_rdata)
  );

  assign in_stall = (state_r != S_IDLE) || !store_ready;
  assign accept   = in_valid && !in_stall;
  assign pos_w    = CMPW'(in_data.position);
  assign cnt_w    = CMPW'(count_r);
  assign val64    = 64'(in_data.value);
  assign rd_s     = val_rdata;
  assign rd64     = 64'(rd_s);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    node_nxt      = node_r;
    rem_nxt       = rem_r;
    status_nxt    = status_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    link_we       = 1'b0;
    link_waddr    = cur_r;
    link_wdata    = free_r;
    link_raddr    = link_rdata;
    val_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        link_raddr = (in_data.command == CMD_INSERT) ? free_r : head_r;
        if (accept) begin
          cmd_nxt    = in_data.command;
          pos_nxt    = in_data.position;
          val_nxt    = val64[DATA_BITS-1:0];
          status_nxt = ST_OK;
          result_nxt = '0;
          cur_nxt    = head_r;
          prev_nxt   = head_r;
          rem_nxt    = in_data.position - 10'd1;
          case (in_data.command)
            CMD_INSERT: begin
              if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else if (free_r == '0) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_POP;
              end
            end
            CMD_DELETE, CMD_READ: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              state_nxt = S_CLR;
            end
          endcase
        end
      end
      S_POP: begin
        node_nxt = free_r;
        free_nxt = link_rdata;
        val_we   = 1'b1;
        if (pos_r == 10'd1) begin
          link_we    = 1'b1;
          link_waddr = free_r;
          link_wdata = head_r;
          head_nxt   = free_r;
          count_nxt  = count_r + IW'(1);
          state_nxt  = S_DONE;
        end else begin
          link_raddr = head_r;
          cur_nxt    = head_r;
          prev_nxt   = head_r;
          rem_nxt    = pos_r - 10'd2;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        if (rem_r == '0) begin
          case (cmd_r)
            CMD_INSERT: begin
              link_we    = 1'b1;
              link_waddr = node_r;
              link_wdata = link_rdata;
              state_nxt  = S_LINK;
            end
            CMD_DELETE: begin
              if (pos_r == 10'd1) begin
                head_nxt = link_rdata;
              end else begin
                link_we    = 1'b1;
                link_waddr = prev_r;
                link_wdata = link_rdata;
              end
              state_nxt = S_TAIL;
            end
            default: begin
              state_nxt = S_TAIL;
            end
          endcase
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_rdata;
          rem_nxt  = rem_r - 10'd1;
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = node_r;
        count_nxt  = count_r + IW'(1);
        state_nxt  = S_DONE;
      end
      S_TAIL: begin
        result_nxt = rd64[31:0];
        if (cmd_r == CMD_DELETE) begin
          link_we    = 1'b1;
          link_waddr = cur_r;
          link_wdata = free_r;
          free_nxt   = cur_r;
          count_nxt  = count_r - IW'(1);
        end
        state_nxt = S_DONE;
      end
      S_CLR: begin
        if (cur_r == '0) begin
          head_nxt  = '0;
          count_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          link_we    = 1'b1;
          link_waddr = cur_r;
          link_wdata = free_r;
          free_nxt   = cur_r;
          cur_nxt    = link_rdata;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt.status       = status_r;
          out_data_nxt.result_value = result_r;
          out_data_nxt.list_length  = 10'(count_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      free_r      <= IW'(1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    node_r     <= node_nxt;
    rem_r      <= rem_nxt;
    status_r   <= status_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_NODE)
    else $error("Element count exceeds the usable node count.");

  a_free_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && store_ready) |-> ((free_r == '0) == (count_r == LAST_NODE)))
    else $error("Free chain state disagrees with the element count.");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> (head_r == '0))
    else $error("Empty list has a nonzero head.");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("Result transaction raised outside the completion state.");

endmodule

@@ dv/tb_static_linked_list_engine.sv @@
// Testbench of the static linked list engine: directed and random commands against a list model.
module tb_static_linked_list_engine;
  import sll_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int DATA_BITS   = 32;
  localparam int CAPACITY    = STORE_DEPTH - 2;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int MIXED_ITEMS = 30;
  localparam int FULL_ITEMS  = 30;

  class list_scoreboard;
    logic signed [31:0] list_vals[$];
    out_item_t          pending_q[$];
    int                 mismatches   = 0;
    int                 results_seen = 0;
    int                 cmd_count[4] = '{default: 0};
    int                 range_count  = 0;
    int                 full_count   = 0;
    int                 peak_length  = 0;

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) begin
        $display("MISMATCH at %0t: %s", $realtime, what);
      end
    endtask

    function void note_command(in_item_t cmd);
      out_item_t   want;
      int unsigned len;
      int          idx;
      len = list_vals.size();
      idx = int'(cmd.position) - 1;
      want.status = ST_OK;
      want.result_value = '0;
      cmd_count[cmd.command]++;
      case (cmd.command)
        CMD_INSERT: begin
          if (cmd.position < 1 || cmd.position > len + 1) begin
            want.status = ST_RANGE;
          end else if (len >= CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            list_vals.insert(idx, cmd.value);
          end
        end
        CMD_DELETE, CMD_READ: begin
          if (cmd.position < 1 || cmd.position > len) begin
            want.status = ST_RANGE;
          end else begin
            want.result_value = list_vals[idx];
            if (cmd.command == CMD_DELETE) begin
              list_vals.delete(idx);
            end
          end
        end
        default: begin
          list_vals.delete();
        end
      endcase
      if (want.status == ST_RANGE) range_count++;
      if (want.status == ST_FULL) full_count++;
      if (list_vals.size() > peak_length) peak_length = list_vals.size();
      want.list_length = 10'(list_vals.size());
      pending_q.push_back(want);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with no command waiting: status %0d value %0d len %0d",
                                  got.status, got.result_value, got.list_length));
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
      if (got.result_value !== want.result_value) begin
        report_mismatch($sformatf("result_value %0d, expected %0d",
                                  got.result_value, want.result_value));
      end
      if (got.list_length !== want.list_length) begin
        report_mismatch($sformatf("list_length %0d, expected %0d",
                                  got.list_length, want.list_length));
      end
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  in_item_t       in_data;
  logic           out_valid;
  logic           out_stall;
  out_item_t      out_data;
  int             send_idle_pct;
  int             recv_idle_pct;
  int unsigned    cycle_count;
  list_scoreboard sb;

  static_linked_list_engine #(
    .STORE_DEPTH(STORE_DEPTH),
    .DATA_BITS  (DATA_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding.",
             cycle_count, sb.pending_q.size());
    $display("static_linked_list_engine test failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_result(out_data);
      end
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [9:0] pos, logic signed [31:0] val);
    in_item_t item;
    item.command  = cmd;
    item.position = pos;
    item.value    = val;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_command(item);
    @(negedge clk);
  endtask

  task automatic send_mixed();
    int unsigned len;
    int unsigned top;
    int unsigned roll;
    int unsigned pick;
    logic [1:0]  cmd;
    logic [9:0]  pos;
    len  = sb.list_vals.size();
    roll = $urandom_range(0, 99);
    if (roll < 42) cmd = CMD_INSERT;
    else if (roll < 67) cmd = CMD_DELETE;
    else if (roll < 97) cmd = CMD_READ;
    else cmd = CMD_CLEAR;
    top  = (cmd == CMD_INSERT) ? len + 1 : len;
    pick = $urandom_range(0, 9);
    if (pick == 0 || top == 0) pos = 10'($urandom);
    else if (pick == 1) pos = 10'(top + 1);
    else if (pick == 2) pos = 10'd1;
    else if (pick == 3) pos = 10'(top);
    else pos = 10'($urandom_range(1, top));
    send_command(cmd, pos, $urandom);
  endtask

  initial begin
    int unsigned len;
    logic [9:0]  pos;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 74;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_command(CMD_READ,   10'd1,    32'sd0);
    send_command(CMD_DELETE, 10'd1,    32'sd0);
    send_command(CMD_INSERT, 10'd0,    32'sd5);
    send_command(CMD_INSERT, 10'd2,    32'sd6);
    send_command(CMD_INSERT, 10'd1,    32'sh7FFFFFFF);
    send_command(CMD_INSERT, 10'd2,    32'sh80000000);
    send_command(CMD_INSERT, 10'd1,    -32'sd1);
    send_command(CMD_INSERT, 10'd4,    32'sd0);
    send_command(CMD_INSERT, 10'd2,    32'sh12345678);
    send_command(CMD_READ,   10'd1,    32'sd0);
    send_command(CMD_READ,   10'd5,    32'sd0);
    send_command(CMD_READ,   10'd6,    32'sd0);
    send_command(CMD_READ,   10'd1023, 32'sd0);
    send_command(CMD_READ,   10'd0,    32'sd0);
    send_command(CMD_DELETE, 10'd5,    32'sd0);
    send_command(CMD_DELETE, 10'd1,    32'sd0);
    send_command(CMD_DELETE, 10'd2,    32'sd0);
    send_command(CMD_DELETE, 10'd0,    32'sd0);
    send_command(CMD_INSERT, 10'd1023, 32'sd9);
    send_command(CMD_CLEAR,  10'd0,    32'sd0);
    send_command(CMD_READ,   10'd1,    32'sd0);
    send_command(CMD_CLEAR,  10'd1023, -32'sd1);
    send_command(CMD_INSERT, 10'd1,    32'sh55555555);
    send_command(CMD_DELETE, 10'd1,    32'sd0);

    repeat (MIXED_ITEMS) send_mixed();

    send_idle_pct = 74;
    recv_idle_pct = 9;
    repeat (MIXED_ITEMS) send_mixed();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sb.list_vals.size() < CAPACITY) begin
      len = sb.list_vals.size();
      if ($urandom_range(0, 19) == 0) begin
        send_command(CMD_READ, 10'($urandom), $urandom);
      end else begin
        if ($urandom_range(0, 9) < 7) pos = 10'($urandom_range(1, (len < 8) ? len + 1 : 8));
        else pos = 10'($urandom_range(1, len + 1));
        send_command(CMD_INSERT, pos, $urandom);
      end
    end
    send_command(CMD_INSERT, 10'd1023, 32'sd1);
    send_command(CMD_INSERT, 10'd0,    32'sd1);
    send_command(CMD_READ,   10'd1022, 32'sd0);
    repeat (FULL_ITEMS) begin
      len = sb.list_vals.size();
      case ($urandom_range(0, 3))
        0: send_command(CMD_INSERT, 10'($urandom), $urandom);
        1: send_command(CMD_READ,   10'($urandom_range(1, len)), $urandom);
        2: send_command(CMD_DELETE, 10'($urandom_range(1, len)), $urandom);
        default: send_command(CMD_INSERT, 10'($urandom_range(1, len + 1)), $urandom);
      endcase
    end
    send_command(CMD_CLEAR, 10'($urandom), $urandom);
    send_command(CMD_READ,  10'd1,         32'sd0);

    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (STORE_DEPTH + 16) @(posedge clk);

    $display("Ran %0d commands (%0d insert, %0d delete, %0d read, %0d clear); %0d checked.",
             sb.cmd_count[CMD_INSERT] + sb.cmd_count[CMD_DELETE] + sb.cmd_count[CMD_READ]
             + sb.cmd_count[CMD_CLEAR], sb.cmd_count[CMD_INSERT], sb.cmd_count[CMD_DELETE],
             sb.cmd_count[CMD_READ], sb.cmd_count[CMD_CLEAR], sb.results_seen);
    $display("Saw %0d position errors, %0d full-store rejections, peak length %0d, %0d mismatches.",
             sb.range_count, sb.full_count, sb.peak_length, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("static_linked_list_engine test passed");
    end else begin
      $display("static_linked_list_engine test failed");
    end
    $finish;
  end

endmodule
